// ===== hw/rtl/altph_pkg.sv =====
`default_nettype none

package altph_pkg;

   localparam int COORD_W   = 24;
   localparam int SPEED_W   = 16;
   localparam int CMD_W     = 16;
   localparam int GAIN_W    = 24;
   localparam int FRAME_W   = 16;
   localparam int CSR_IDX_W = 3;

   localparam int ERR_W   = 27;
   localparam int OPND_W  = 40;
   localparam int HALF_W  = 20;
   localparam int MUL_A_W = 21;
   localparam int MUL_B_W = 25;
   localparam int PROD_W  = 46;
   localparam int ACC_W   = 66;
   localparam int TOTAL_W = 52;
   localparam int OUT_W   = 29;
   localparam int INTEG_W = 30;
   localparam int SPD_Q_W = 18;

   localparam longint SAT_LIM  = 64'sd549755813887;
   localparam longint HALF_Q28 = 64'sd134217728;
   localparam longint ONE_Q28  = 64'sd268435456;
   localparam int     ERR_NEAR = 1600;
   localparam int     SPD_LIM  = 16384;
   localparam int     THR_MID  = 16384;
   localparam int     THR_RND  = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_TIME = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KP_AVOID   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_AVOID   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KFB_AVOID  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KP_NORMAL  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_NORMAL  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_KFB_NORMAL = 3'd6;

   localparam logic [FRAME_W-1:0] RST_FRAME_TIME = 16'd3277;
   localparam logic [GAIN_W-1:0]  RST_KP_AVOID   = 24'd167772;
   localparam logic [GAIN_W-1:0]  RST_KI_AVOID   = 24'd83886;
   localparam logic [GAIN_W-1:0]  RST_KFB_AVOID  = 24'd167772;
   localparam logic [GAIN_W-1:0]  RST_KP_NORMAL  = 24'd167772;
   localparam logic [GAIN_W-1:0]  RST_KI_NORMAL  = 24'd3355;
   localparam logic [GAIN_W-1:0]  RST_KFB_NORMAL = 24'd83886;

   // multiplier operand pairs
   localparam logic [2:0] SRC_P  = 3'd0;
   localparam logic [2:0] SRC_FB = 3'd1;
   localparam logic [2:0] SRC_W  = 3'd2;
   localparam logic [2:0] SRC_D  = 3'd3;
   localparam logic [2:0] SRC_S  = 3'd4;

   // accumulator control
   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;

   // datapath register updates
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_LOAD   = 3'd1;
   localparam logic [2:0] OP_TOTAL  = 3'd2;
   localparam logic [2:0] OP_CLAMP  = 3'd3;
   localparam logic [2:0] OP_U      = 3'd4;
   localparam logic [2:0] OP_W      = 3'd5;
   localparam logic [2:0] OP_INT    = 3'd6;
   localparam logic [2:0] OP_RESULT = 3'd7;

   typedef struct packed {
      logic [2:0] src;
      logic       hi;
      logic [1:0] acc;
      logic [2:0] op;
   } cmd_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_time;
      logic [GAIN_W-1:0]  kp_avoid;
      logic [GAIN_W-1:0]  ki_avoid;
      logic [GAIN_W-1:0]  kfb_avoid;
      logic [GAIN_W-1:0]  kp_normal;
      logic [GAIN_W-1:0]  ki_normal;
      logic [GAIN_W-1:0]  kfb_normal;
   } gains_type;

endpackage

`default_nettype wire

// ===== hw/rtl/altitude_pi_hold_unit.sv =====
`default_nettype none

// channel   direction  transaction
// req_*     in         height setpoint, vehicle z, offset, ground level, speed, avoid flag
// rsp_*     out        throttle command, pitch stick
// csr_*     in         gain and frame time register write, no wait
//
// an accepted item steps through the multiply states and its result is registered when
// the final write is done; the next item is taken only after the unit returns to idle
// the sequence is built around the one shared 21x25 multiplier: five products,
// each done in two 20-bit halves and then summed
// reset clears the integral term and loads the register defaults
// a held result stalls only the final write of the next item

module altitude_pi_hold_unit import altph_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [COORD_W-1:0]  req_height_setpoint,
   input  logic signed [COORD_W-1:0]  req_vehicle_z,
   input  logic signed [COORD_W-1:0]  req_height_offset,
   input  logic signed [COORD_W-1:0]  req_ground_level,
   input  logic signed [SPEED_W-1:0]  req_speed_demand,
   input  logic                       req_ground_avoid,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic        [CMD_W-1:0]    rsp_throttle_cmd,
   output logic signed [CMD_W-1:0]    rsp_pitch_stick,
   input  logic                       csr_we,
   input  logic        [CSR_IDX_W-1:0] csr_index,
   input  logic        [GAIN_W-1:0]   csr_wdata
);

   gains_type gains;
   cmd_type   cmd;

   altph_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .gains     (gains)
   );

   altph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   altph_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .gains               (gains),
      .req_height_setpoint (req_height_setpoint),
      .req_vehicle_z       (req_vehicle_z),
      .req_height_offset   (req_height_offset),
      .req_ground_level    (req_ground_level),
      .req_speed_demand    (req_speed_demand),
      .req_ground_avoid    (req_ground_avoid),
      .rsp_throttle_cmd    (rsp_throttle_cmd),
      .rsp_pitch_stick     (rsp_pitch_stick)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/altph_csr.sv =====
`default_nettype none

module altph_csr import altph_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata,
   output gains_type            gains
);

   gains_type gains_ff;
   gains_type gains_in;

   always_comb begin
      gains_in = gains_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_TIME: gains_in.frame_time = csr_wdata[FRAME_W-1:0];
            CSR_KP_AVOID:   gains_in.kp_avoid   = csr_wdata;
            CSR_KI_AVOID:   gains_in.ki_avoid   = csr_wdata;
            CSR_KFB_AVOID:  gains_in.kfb_avoid  = csr_wdata;
            CSR_KP_NORMAL:  gains_in.kp_normal  = csr_wdata;
            CSR_KI_NORMAL:  gains_in.ki_normal  = csr_wdata;
            CSR_KFB_NORMAL: gains_in.kfb_normal = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.frame_time <= RST_FRAME_TIME;
         gains_ff.kp_avoid   <= RST_KP_AVOID;
         gains_ff.ki_avoid   <= RST_KI_AVOID;
         gains_ff.kfb_avoid  <= RST_KFB_AVOID;
         gains_ff.kp_normal  <= RST_KP_NORMAL;
         gains_ff.ki_normal  <= RST_KI_NORMAL;
         gains_ff.kfb_normal <= RST_KFB_NORMAL;
      end else begin
         gains_ff <= gains_in;
      end
   end

   assign gains = gains_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/altph_ctrl.sv =====
`default_nettype none

module altph_ctrl import altph_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_P_LO   = 5'd1;
   localparam logic [4:0] ST_P_HI   = 5'd2;
   localparam logic [4:0] ST_P_ACC  = 5'd3;
   localparam logic [4:0] ST_TOTAL  = 5'd4;
   localparam logic [4:0] ST_CLAMP  = 5'd5;
   localparam logic [4:0] ST_FB_LO  = 5'd6;
   localparam logic [4:0] ST_FB_HI  = 5'd7;
   localparam logic [4:0] ST_FB_ACC = 5'd8;
   localparam logic [4:0] ST_U      = 5'd9;
   localparam logic [4:0] ST_W_LO   = 5'd10;
   localparam logic [4:0] ST_W_HI   = 5'd11;
   localparam logic [4:0] ST_W_ACC  = 5'd12;
   localparam logic [4:0] ST_W      = 5'd13;
   localparam logic [4:0] ST_D_LO   = 5'd14;
   localparam logic [4:0] ST_D_HI   = 5'd15;
   localparam logic [4:0] ST_D_ACC  = 5'd16;
   localparam logic [4:0] ST_S_LO   = 5'd17;
   localparam logic [4:0] ST_S_HI   = 5'd18;
   localparam logic [4:0] ST_S_ACC  = 5'd19;
   localparam logic [4:0] ST_RESULT = 5'd20;

   logic [4:0] state_ff;
   logic [4:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       rsp_load;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      cmd.src   = SRC_P;
      cmd.hi    = 1'b0;
      cmd.acc   = ACC_HOLD;
      cmd.op    = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_P_LO;
            end
         end
         ST_P_LO: begin
            cmd.src  = SRC_P;
            state_in = ST_P_HI;
         end
         ST_P_HI: begin
            cmd.src  = SRC_P;
            cmd.hi   = 1'b1;
            cmd.acc  = ACC_LOAD;
            state_in = ST_P_ACC;
         end
         ST_P_ACC: begin
            cmd.acc  = ACC_ADD;
            state_in = ST_TOTAL;
         end
         ST_TOTAL: begin
            cmd.op   = OP_TOTAL;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.op   = OP_CLAMP;
            state_in = ST_FB_LO;
         end
         ST_FB_LO: begin
            cmd.src  = SRC_FB;
            state_in = ST_FB_HI;
         end
         ST_FB_HI: begin
            cmd.src  = SRC_FB;
            cmd.hi   = 1'b1;
            cmd.acc  = ACC_LOAD;
            state_in = ST_FB_ACC;
         end
         ST_FB_ACC: begin
            cmd.acc  = ACC_ADD;
            state_in = ST_U;
         end
         ST_U: begin
            cmd.op   = OP_U;
            state_in = ST_W_LO;
         end
         ST_W_LO: begin
            cmd.src  = SRC_W;
            state_in = ST_W_HI;
         end
         ST_W_HI: begin
            cmd.src  = SRC_W;
            cmd.hi   = 1'b1;
            cmd.acc  = ACC_LOAD;
            state_in = ST_W_ACC;
         end
         ST_W_ACC: begin
            cmd.acc  = ACC_ADD;
            state_in = ST_W;
         end
         ST_W: begin
            cmd.op   = OP_W;
            state_in = ST_D_LO;
         end
         ST_D_LO: begin
            cmd.src  = SRC_D;
            state_in = ST_D_HI;
         end
         ST_D_HI: begin
            cmd.src  = SRC_D;
            cmd.hi   = 1'b1;
            cmd.acc  = ACC_LOAD;
            state_in = ST_D_ACC;
         end
         ST_D_ACC: begin
            cmd.acc  = ACC_ADD;
            state_in = ST_S_LO;
         end
         ST_S_LO: begin
            cmd.src  = SRC_S;
            cmd.op   = OP_INT;
            state_in = ST_S_HI;
         end
         ST_S_HI: begin
            cmd.src  = SRC_S;
            cmd.hi   = 1'b1;
            cmd.acc  = ACC_LOAD;
            state_in = ST_S_ACC;
         end
         ST_S_ACC: begin
            cmd.acc  = ACC_ADD;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = OP_RESULT;
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/altph_dp.sv =====
`default_nettype none

module altph_dp import altph_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   input  gains_type                  gains,
   input  logic signed [COORD_W-1:0]  req_height_setpoint,
   input  logic signed [COORD_W-1:0]  req_vehicle_z,
   input  logic signed [COORD_W-1:0]  req_height_offset,
   input  logic signed [COORD_W-1:0]  req_ground_level,
   input  logic signed [SPEED_W-1:0]  req_speed_demand,
   input  logic                       req_ground_avoid,
   output logic        [CMD_W-1:0]    rsp_throttle_cmd,
   output logic signed [CMD_W-1:0]    rsp_pitch_stick
);

   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [SPEED_W-1:0] spd_ff, spd_in;
   logic                      avoid_ff, avoid_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic signed [OPND_W-1:0]  psat_ff, psat_in;
   logic signed [OUT_W-1:0]   out_ff, out_in;
   logic signed [OPND_W-1:0]  dsat_ff, dsat_in;
   logic signed [OPND_W-1:0]  u_ff, u_in;
   logic signed [OPND_W-1:0]  w_ff, w_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic        [CMD_W-1:0]   throttle_ff, throttle_in;
   logic signed [CMD_W-1:0]   pitch_ff, pitch_in;

   logic        [GAIN_W-1:0]  kp, ki, kfb;
   logic signed [OPND_W-1:0]  opnd_a;
   logic signed [MUL_B_W-1:0] opnd_b;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [OPND_W-1:0]  speed_factor;
   logic signed [ACC_W-1:0]   prod_ext;

   logic signed [TOTAL_W-1:0] p_val;
   logic signed [TOTAL_W-1:0] diff;
   logic signed [OPND_W:0]    fb;
   logic signed [OPND_W+1:0]  u_diff;
   logic signed [OPND_W-1:0]  d_step;
   logic signed [OPND_W:0]    i_sum;
   logic signed [OPND_W:0]    i_lim;
   logic signed [PROD_W-1:0]  s_rnd;
   logic signed [SPD_Q_W-1:0] s_val;
   logic signed [SPD_Q_W-1:0] s_neg;
   logic signed [OUT_W:0]     o_rnd;
   logic signed [SPD_Q_W-1:0] thr_val;

   assign kp  = avoid_ff ? gains.kp_avoid  : gains.kp_normal;
   assign ki  = avoid_ff ? gains.ki_avoid  : gains.ki_normal;
   assign kfb = avoid_ff ? gains.kfb_avoid : gains.kfb_normal;

   assign speed_factor = OPND_W'(ONE_Q28)
                       - {{(OPND_W-OUT_W-1){out_ff[OUT_W-1]}}, out_ff, 1'b0};

   // shared multiplier, one 20-bit half of operand a per cycle
   always_comb begin
      unique case (cmd.src)
         SRC_P: begin
            opnd_a = {{(OPND_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
            opnd_b = {1'b0, kp};
         end
         SRC_FB: begin
            opnd_a = dsat_ff;
            opnd_b = {1'b0, kfb};
         end
         SRC_W: begin
            opnd_a = u_ff;
            opnd_b = {1'b0, ki};
         end
         SRC_D: begin
            opnd_a = w_ff;
            opnd_b = {{(MUL_B_W-FRAME_W){1'b0}}, gains.frame_time};
         end
         SRC_S: begin
            opnd_a = speed_factor;
            opnd_b = {{(MUL_B_W-SPEED_W){spd_ff[SPEED_W-1]}}, spd_ff};
         end
         default: begin
            opnd_a = '0;
            opnd_b = '0;
         end
      endcase
      if (cmd.hi) begin
         mul_a = {opnd_a[OPND_W-1], opnd_a[OPND_W-1:HALF_W]};
      end else begin
         mul_a = {1'b0, opnd_a[HALF_W-1:0]};
      end
      prod_in  = mul_a * opnd_b;
      prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      case (cmd.acc)
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + (prod_ext <<< HALF_W);
         default:  acc_in = acc_ff;
      endcase
   end

   always_comb begin
      err_in      = err_ff;
      spd_in      = spd_ff;
      avoid_in    = avoid_ff;
      total_in    = total_ff;
      psat_in     = psat_ff;
      out_in      = out_ff;
      dsat_in     = dsat_ff;
      u_in        = u_ff;
      w_in        = w_ff;
      integ_in    = integ_ff;
      throttle_in = throttle_ff;
      pitch_in    = pitch_ff;

      p_val   = acc_ff[TOTAL_W-1:0];
      diff    = '0;
      fb      = acc_ff[OPND_W+GAIN_W:GAIN_W];
      u_diff  = {{2{psat_ff[OPND_W-1]}}, psat_ff} - {fb[OPND_W], fb};
      d_step  = acc_ff[OPND_W+FRAME_W-1:FRAME_W];
      i_sum   = {{(OPND_W+1-INTEG_W){integ_ff[INTEG_W-1]}}, integ_ff}
              + {d_step[OPND_W-1], d_step};
      i_lim   = (err_ff > -ERR_NEAR && err_ff < ERR_NEAR) ? (OPND_W+1)'(HALF_Q28)
                                                          : (OPND_W+1)'(ONE_Q28);
      s_rnd   = acc_ff[PROD_W-1:0] + PROD_W'(HALF_Q28);
      s_val   = {{(SPD_Q_W-SPEED_W){spd_ff[SPEED_W-1]}}, spd_ff};
      s_neg   = '0;
      o_rnd   = {out_ff[OUT_W-1], out_ff} + (OUT_W+1)'(THR_RND);
      thr_val = SPD_Q_W'(THR_MID) + {o_rnd[OUT_W], o_rnd[OUT_W:13]};

      case (cmd.op)
         OP_LOAD: begin
            err_in = {{(ERR_W-COORD_W){req_height_setpoint[COORD_W-1]}}, req_height_setpoint}
                   + {{(ERR_W-COORD_W){req_vehicle_z[COORD_W-1]}}, req_vehicle_z}
                   + {{(ERR_W-COORD_W){req_height_offset[COORD_W-1]}}, req_height_offset}
                   - {{(ERR_W-COORD_W){req_ground_level[COORD_W-1]}}, req_ground_level};
            spd_in   = req_speed_demand;
            avoid_in = req_ground_avoid;
         end
         OP_TOTAL: begin
            total_in = {{(TOTAL_W-INTEG_W){integ_ff[INTEG_W-1]}}, integ_ff} + p_val;
            if (p_val > SAT_LIM) begin
               psat_in = OPND_W'(SAT_LIM);
            end else if (p_val < -SAT_LIM) begin
               psat_in = OPND_W'(-SAT_LIM);
            end else begin
               psat_in = p_val[OPND_W-1:0];
            end
         end
         OP_CLAMP: begin
            if (total_ff > HALF_Q28) begin
               out_in = OUT_W'(HALF_Q28);
               diff   = total_ff - TOTAL_W'(HALF_Q28);
            end else if (total_ff < -HALF_Q28) begin
               out_in = OUT_W'(-HALF_Q28);
               diff   = total_ff + TOTAL_W'(HALF_Q28);
            end else begin
               out_in = total_ff[OUT_W-1:0];
            end
            if (diff > SAT_LIM) begin
               dsat_in = OPND_W'(SAT_LIM);
            end else if (diff < -SAT_LIM) begin
               dsat_in = OPND_W'(-SAT_LIM);
            end else begin
               dsat_in = diff[OPND_W-1:0];
            end
         end
         OP_U: begin
            if (u_diff > SAT_LIM) begin
               u_in = OPND_W'(SAT_LIM);
            end else if (u_diff < -SAT_LIM) begin
               u_in = OPND_W'(-SAT_LIM);
            end else begin
               u_in = u_diff[OPND_W-1:0];
            end
         end
         OP_W: begin
            w_in = acc_ff[OPND_W+GAIN_W-1:GAIN_W];
         end
         OP_INT: begin
            if (i_sum > i_lim) begin
               integ_in = i_lim[INTEG_W-1:0];
            end else if (i_sum < -i_lim) begin
               integ_in = INTEG_W'(-i_lim);
            end else begin
               integ_in = i_sum[INTEG_W-1:0];
            end
         end
         OP_RESULT: begin
            // climb in avoid mode scales the speed demand down
            if (avoid_ff && !out_ff[OUT_W-1]) begin
               s_val = s_rnd[PROD_W-1:28];
            end
            if (s_val > SPD_LIM) begin
               s_neg = -SPD_Q_W'(SPD_LIM);
            end else if (s_val < -SPD_LIM) begin
               s_neg = SPD_Q_W'(SPD_LIM);
            end else begin
               s_neg = -s_val;
            end
            pitch_in    = s_neg[CMD_W-1:0];
            throttle_in = thr_val[CMD_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else begin
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      spd_ff      <= spd_in;
      avoid_ff    <= avoid_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      total_ff    <= total_in;
      psat_ff     <= psat_in;
      out_ff      <= out_in;
      dsat_ff     <= dsat_in;
      u_ff        <= u_in;
      w_ff        <= w_in;
      throttle_ff <= throttle_in;
      pitch_ff    <= pitch_in;
   end

   assign rsp_throttle_cmd = throttle_ff;
   assign rsp_pitch_stick  = pitch_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/altph_checker.sv =====
`default_nettype none

module altph_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic        [15:0] rsp_throttle_cmd,
   input logic signed [15:0] rsp_pitch_stick
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_throttle_cmd)
                                  && $stable(rsp_pitch_stick))
      else $error("result changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction taken while busy");

   a_throttle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_throttle_cmd <= 16'd32768)
      else $error("throttle out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pitch_stick >= -16'sd16384 && rsp_pitch_stick <= 16'sd16384)
      else $error("pitch stick out of range");

endmodule

bind altitude_pi_hold_unit altph_checker u_altph_checker (.*);

`default_nettype wire
